// ===== sv/lrups_pkg.sv =====
package lrups_pkg;

   localparam int MAX_FRAMES = 16;
   localparam int MAX_PAGES  = 64;

   localparam int FRAME_W    = 4;
   localparam int PAGE_W     = 6;
   localparam int SLOT_W     = 6;
   localparam int NF_W       = 5;
   localparam int NS_W       = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES_IN_USE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VIRTUAL_PAGES = 2'd1;

   localparam logic [NF_W-1:0] FRAMES_IN_USE_RESET = 5'd16;
   localparam logic [NS_W-1:0] VIRTUAL_PAGES_RESET = 7'd64;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FSCAN,
      ST_CHECK,
      ST_SWAP,
      ST_COMMIT
   } lrups_state_type;

   // Commands from the sequencer to the datapath
   typedef struct packed {
      logic load;
      logic fscan_en;
      logic sscan_en;
      logic commit;
   } lrups_cmd_type;

   // Status from the datapath to the sequencer
   typedef struct packed {
      logic fscan_last;
      logic sscan_done;
      logic hit;
   } lrups_stat_type;

endpackage

// ===== sv/lrups_ctrl.sv =====
module lrups_ctrl import lrups_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  lrups_stat_type stat,
   output lrups_cmd_type  cmd,
   output logic           busy
);

   lrups_state_type state_ff;
   lrups_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_FSCAN;
            end
         end
         ST_FSCAN: begin
            cmd.fscan_en = 1'b1;
            if (stat.fscan_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = stat.hit ? ST_COMMIT : ST_SWAP;
         end
         ST_SWAP: begin
            cmd.sscan_en = 1'b1;
            if (stat.sscan_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== sv/lrups_datapath.sv =====
module lrups_datapath import lrups_pkg::*; #(
   parameter int AGE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic [PAGE_W-1:0]     req_page,
   input  lrups_cmd_type         cmd,
   output lrups_stat_type        stat,
   output logic                  rsp_valid,
   output logic                  rsp_hit,
   output logic [FRAME_W-1:0]    rsp_frame,
   output logic                  rsp_evicted_valid,
   output logic [PAGE_W-1:0]     rsp_evicted_page,
   output logic                  rsp_swap_out_valid,
   output logic [SLOT_W-1:0]     rsp_swap_out_slot,
   output logic                  rsp_swap_in_valid,
   output logic [SLOT_W-1:0]     rsp_swap_in_slot
);

   // configuration
   logic [NF_W-1:0]     frames_in_use_ff, frames_in_use_in;
   logic [NS_W-1:0]     virtual_pages_ff, virtual_pages_in;
   logic [NF_W-1:0]     nf_clamp;
   logic [NS_W-1:0]     ns_clamp;

   // per-item context
   logic [NF_W-1:0]     nf_ff, nf_in;
   logic [NS_W-1:0]     ns_ff, ns_in;
   logic [PAGE_W-1:0]   ref_ff, ref_in;

   // frame scan
   logic [FRAME_W-1:0]  fidx_ff, fidx_in;
   logic                hit_found_ff, hit_found_in;
   logic [FRAME_W-1:0]  hit_idx_ff, hit_idx_in;
   logic                empty_found_ff, empty_found_in;
   logic [FRAME_W-1:0]  empty_idx_ff, empty_idx_in;
   logic                old_found_ff, old_found_in;
   logic [FRAME_W-1:0]  old_idx_ff, old_idx_in;
   logic [AGE_BITS-1:0] old_age_ff, old_age_in;

   // swap scan
   logic [SLOT_W-1:0]   sidx_ff, sidx_in;
   logic                issue_done_ff, issue_done_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [SLOT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [PAGE_W-1:0]   rd_page_ff;
   logic                rd_used_ff;
   logic                free_found_ff, free_found_in;
   logic [SLOT_W-1:0]   free_idx_ff, free_idx_in;
   logic                match_found_ff, match_found_in;
   logic [SLOT_W-1:0]   match_idx_ff, match_idx_in;

   // frame table and swap area
   logic [PAGE_W-1:0]   frame_page_ff  [MAX_FRAMES];
   logic [PAGE_W-1:0]   frame_page_in  [MAX_FRAMES];
   logic                frame_valid_ff [MAX_FRAMES];
   logic                frame_valid_in [MAX_FRAMES];
   logic [AGE_BITS-1:0] frame_age_ff   [MAX_FRAMES];
   logic [AGE_BITS-1:0] frame_age_in   [MAX_FRAMES];
   logic                swap_used_ff   [MAX_PAGES];
   logic                swap_used_in   [MAX_PAGES];
   logic [PAGE_W-1:0]   swap_mem       [MAX_PAGES];

   // result
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic [FRAME_W-1:0]  rsp_frame_ff, rsp_frame_in;
   logic                rsp_ev_valid_ff, rsp_ev_valid_in;
   logic [PAGE_W-1:0]   rsp_ev_page_ff, rsp_ev_page_in;
   logic                rsp_so_valid_ff, rsp_so_valid_in;
   logic [SLOT_W-1:0]   rsp_so_slot_ff, rsp_so_slot_in;
   logic                rsp_si_valid_ff, rsp_si_valid_in;
   logic [SLOT_W-1:0]   rsp_si_slot_ff, rsp_si_slot_in;

   logic                cur_valid;
   logic [PAGE_W-1:0]   cur_page;
   logic [AGE_BITS-1:0] cur_age;
   logic                fscan_last;
   logic                sscan_last;
   logic [FRAME_W-1:0]  victim_idx;
   logic                victim_occ;
   logic [PAGE_W-1:0]   ev_page;
   logic                miss_commit;
   logic                swap_write;

   always_comb begin
      frames_in_use_in = frames_in_use_ff;
      virtual_pages_in = virtual_pages_ff;
      if (csr_write && (csr_index == CSR_FRAMES_IN_USE)) begin
         frames_in_use_in = csr_data[NF_W-1:0];
      end
      if (csr_write && (csr_index == CSR_VIRTUAL_PAGES)) begin
         virtual_pages_in = csr_data[NS_W-1:0];
      end

      if (frames_in_use_ff == '0) begin
         nf_clamp = NF_W'(1);
      end else if (frames_in_use_ff > NF_W'(MAX_FRAMES)) begin
         nf_clamp = NF_W'(MAX_FRAMES);
      end else begin
         nf_clamp = frames_in_use_ff;
      end
      if (virtual_pages_ff == '0) begin
         ns_clamp = NS_W'(1);
      end else if (virtual_pages_ff > NS_W'(MAX_PAGES)) begin
         ns_clamp = NS_W'(MAX_PAGES);
      end else begin
         ns_clamp = virtual_pages_ff;
      end
   end

   assign cur_valid  = frame_valid_ff[fidx_ff];
   assign cur_page   = frame_page_ff[fidx_ff];
   assign cur_age    = frame_age_ff[fidx_ff];
   assign fscan_last = (({1'b0, fidx_ff} + NF_W'(1)) == nf_ff);
   assign sscan_last = (({1'b0, sidx_ff} + NS_W'(1)) == ns_ff);

   // first empty frame wins, else the oldest one
   assign victim_idx  = empty_found_ff ? empty_idx_ff : old_idx_ff;
   assign victim_occ  = !empty_found_ff;
   assign ev_page     = frame_page_ff[victim_idx];
   assign miss_commit = cmd.commit && !hit_found_ff;
   assign swap_write  = miss_commit && victim_occ && free_found_ff;

   // scan bookkeeping
   always_comb begin
      nf_in          = nf_ff;
      ns_in          = ns_ff;
      ref_in         = ref_ff;
      fidx_in        = fidx_ff;
      hit_found_in   = hit_found_ff;
      hit_idx_in     = hit_idx_ff;
      empty_found_in = empty_found_ff;
      empty_idx_in   = empty_idx_ff;
      old_found_in   = old_found_ff;
      old_idx_in     = old_idx_ff;
      old_age_in     = old_age_ff;
      sidx_in        = sidx_ff;
      issue_done_in  = issue_done_ff;
      rd_vld_in      = 1'b0;
      rd_idx_in      = rd_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;

      if (cmd.load) begin
         nf_in          = nf_clamp;
         ns_in          = ns_clamp;
         ref_in         = req_page;
         fidx_in        = '0;
         hit_found_in   = 1'b0;
         empty_found_in = 1'b0;
         old_found_in   = 1'b0;
         sidx_in        = '0;
         issue_done_in  = 1'b0;
         free_found_in  = 1'b0;
         match_found_in = 1'b0;
      end

      if (cmd.fscan_en) begin
         if (cur_valid && (cur_page == ref_ff) && !hit_found_ff) begin
            hit_found_in = 1'b1;
            hit_idx_in   = fidx_ff;
         end
         if (!cur_valid && !empty_found_ff) begin
            empty_found_in = 1'b1;
            empty_idx_in   = fidx_ff;
         end
         // strict compare keeps the lowest frame on equal ages
         if (cur_valid && (!old_found_ff || (cur_age > old_age_ff))) begin
            old_found_in = 1'b1;
            old_idx_in   = fidx_ff;
            old_age_in   = cur_age;
         end
         fidx_in = fidx_ff + FRAME_W'(1);
      end

      // one slot issued per cycle; its used bit and page come back next cycle
      if (cmd.sscan_en && !issue_done_ff) begin
         rd_vld_in = 1'b1;
         rd_idx_in = sidx_ff;
         if (sscan_last) begin
            issue_done_in = 1'b1;
         end else begin
            sidx_in = sidx_ff + SLOT_W'(1);
         end
      end

      if (rd_vld_ff && !rd_used_ff && !free_found_ff) begin
         free_found_in = 1'b1;
         free_idx_in   = rd_idx_ff;
      end

      // the evicted page never equals the reference, so matching on the
      // contents before the swap-out write gives the same slot
      if (rd_vld_ff && rd_used_ff && (rd_page_ff == ref_ff) && !match_found_ff) begin
         match_found_in = 1'b1;
         match_idx_in   = rd_idx_ff;
      end
   end

   // table update at commit
   always_comb begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
         frame_page_in[i]  = frame_page_ff[i];
         frame_valid_in[i] = frame_valid_ff[i];
         frame_age_in[i]   = frame_age_ff[i];
         if (cmd.commit && (NF_W'(i) < nf_ff) && frame_valid_ff[i] &&
             (frame_age_ff[i] != '1)) begin
            frame_age_in[i] = frame_age_ff[i] + AGE_BITS'(1);
         end
      end
      if (cmd.commit && hit_found_ff) begin
         frame_age_in[hit_idx_ff] = '0;
      end
      if (miss_commit) begin
         frame_page_in[victim_idx]  = ref_ff;
         frame_valid_in[victim_idx] = 1'b1;
         frame_age_in[victim_idx]   = '0;
      end

      for (int j = 0; j < MAX_PAGES; j++) begin
         swap_used_in[j] = swap_used_ff[j];
      end
      if (swap_write) begin
         swap_used_in[free_idx_ff] = 1'b1;
      end
      if (miss_commit && match_found_ff) begin
         swap_used_in[match_idx_ff] = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in    = cmd.commit;
      rsp_hit_in      = rsp_hit_ff;
      rsp_frame_in    = rsp_frame_ff;
      rsp_ev_valid_in = rsp_ev_valid_ff;
      rsp_ev_page_in  = rsp_ev_page_ff;
      rsp_so_valid_in = rsp_so_valid_ff;
      rsp_so_slot_in  = rsp_so_slot_ff;
      rsp_si_valid_in = rsp_si_valid_ff;
      rsp_si_slot_in  = rsp_si_slot_ff;
      if (cmd.commit) begin
         rsp_hit_in      = hit_found_ff;
         rsp_frame_in    = hit_found_ff ? hit_idx_ff : victim_idx;
         rsp_ev_valid_in = miss_commit && victim_occ;
         rsp_ev_page_in  = (miss_commit && victim_occ) ? ev_page : '0;
         rsp_so_valid_in = swap_write;
         rsp_so_slot_in  = swap_write ? free_idx_ff : '0;
         rsp_si_valid_in = miss_commit && match_found_ff;
         rsp_si_slot_in  = (miss_commit && match_found_ff) ? match_idx_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_in_use_ff <= FRAMES_IN_USE_RESET;
         virtual_pages_ff <= VIRTUAL_PAGES_RESET;
         hit_found_ff     <= 1'b0;
         empty_found_ff   <= 1'b0;
         old_found_ff     <= 1'b0;
         issue_done_ff    <= 1'b0;
         rd_vld_ff        <= 1'b0;
         free_found_ff    <= 1'b0;
         match_found_ff   <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         for (int i = 0; i < MAX_FRAMES; i++) begin
            frame_valid_ff[i] <= 1'b0;
            frame_age_ff[i]   <= '0;
         end
         for (int j = 0; j < MAX_PAGES; j++) begin
            swap_used_ff[j] <= 1'b0;
         end
      end else begin
         frames_in_use_ff <= frames_in_use_in;
         virtual_pages_ff <= virtual_pages_in;
         hit_found_ff     <= hit_found_in;
         empty_found_ff   <= empty_found_in;
         old_found_ff     <= old_found_in;
         issue_done_ff    <= issue_done_in;
         rd_vld_ff        <= rd_vld_in;
         free_found_ff    <= free_found_in;
         match_found_ff   <= match_found_in;
         rsp_valid_ff     <= rsp_valid_in;
         for (int i = 0; i < MAX_FRAMES; i++) begin
            frame_valid_ff[i] <= frame_valid_in[i];
            frame_age_ff[i]   <= frame_age_in[i];
         end
         for (int j = 0; j < MAX_PAGES; j++) begin
            swap_used_ff[j] <= swap_used_in[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      nf_ff           <= nf_in;
      ns_ff           <= ns_in;
      ref_ff          <= ref_in;
      fidx_ff         <= fidx_in;
      hit_idx_ff      <= hit_idx_in;
      empty_idx_ff    <= empty_idx_in;
      old_idx_ff      <= old_idx_in;
      old_age_ff      <= old_age_in;
      sidx_ff         <= sidx_in;
      rd_idx_ff       <= rd_idx_in;
      free_idx_ff     <= free_idx_in;
      match_idx_ff    <= match_idx_in;
      rsp_hit_ff      <= rsp_hit_in;
      rsp_frame_ff    <= rsp_frame_in;
      rsp_ev_valid_ff <= rsp_ev_valid_in;
      rsp_ev_page_ff  <= rsp_ev_page_in;
      rsp_so_valid_ff <= rsp_so_valid_in;
      rsp_so_slot_ff  <= rsp_so_slot_in;
      rsp_si_valid_ff <= rsp_si_valid_in;
      rsp_si_slot_ff  <= rsp_si_slot_in;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         frame_page_ff[i] <= frame_page_in[i];
      end
   end

   // swap page memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (swap_write) begin
         swap_mem[free_idx_ff] <= ev_page;
      end
      if (cmd.sscan_en && !issue_done_ff) begin
         rd_page_ff <= swap_mem[sidx_ff];
         rd_used_ff <= swap_used_ff[sidx_ff];
      end
   end

   assign stat.fscan_last = fscan_last;
   assign stat.sscan_done = issue_done_ff && !rd_vld_ff;
   assign stat.hit        = hit_found_ff;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_frame          = rsp_frame_ff;
   assign rsp_evicted_valid  = rsp_ev_valid_ff;
   assign rsp_evicted_page   = rsp_ev_page_ff;
   assign rsp_swap_out_valid = rsp_so_valid_ff;
   assign rsp_swap_out_slot  = rsp_so_slot_ff;
   assign rsp_swap_in_valid  = rsp_si_valid_ff;
   assign rsp_swap_in_slot   = rsp_si_slot_ff;

   a_slots_distinct: assert property (@(posedge clock) disable iff (reset)
      (miss_commit && free_found_ff && match_found_ff) |->
         (free_idx_ff != match_idx_ff))
      else $error("swap-out and swap-in picked the same slot");

   a_evict_not_ref: assert property (@(posedge clock) disable iff (reset)
      (miss_commit && victim_occ) |-> (ev_page != ref_ff))
      else $error("evicted page equals the referenced page");

   a_victim_exists: assert property (@(posedge clock) disable iff (reset)
      miss_commit |-> (empty_found_ff || old_found_ff))
      else $error("miss committed without a victim");

   a_fscan_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.fscan_en |-> ({1'b0, fidx_ff} < nf_ff))
      else $error("frame scan ran past the active frames");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");

endmodule

// ===== sv/lru_page_replacement_swap_unit.sv =====
// LRU page replacement unit with a swap area.
//
// Request: drive req_page and raise start; the item is taken at a rising
// edge where start is high and busy is low. busy stays high until the
// result is produced. Result: rsp_valid pulses for exactly one cycle with
// all rsp_ fields; the receiver cannot hold it off, so capture it then.
// Configuration: csr_write with csr_index 0 (frames_in_use) or 1
// (virtual_pages) and csr_data; write only while busy is low.
//
// Flow, with nf active frames and ns active swap slots: the frame table
// is scanned one frame per cycle, then checked. A hit then commits. A
// miss first adds one pass over the swap slots through the single read
// port of the swap memory, then commits. rsp_valid is registered from
// the commit. busy falls in the strobe cycle, so the next item may be
// accepted while the result is shown.
// Reset: all frames empty, all ages zero, all swap slots free,
// frames_in_use = 16, virtual_pages = 64. No clearing pass is needed.
module lru_page_replacement_swap_unit import lrups_pkg::*; #(
   parameter int AGE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [PAGE_W-1:0]     req_page,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  rsp_valid,
   output logic                  rsp_hit,
   output logic [FRAME_W-1:0]    rsp_frame,
   output logic                  rsp_evicted_valid,
   output logic [PAGE_W-1:0]     rsp_evicted_page,
   output logic                  rsp_swap_out_valid,
   output logic [SLOT_W-1:0]     rsp_swap_out_slot,
   output logic                  rsp_swap_in_valid,
   output logic [SLOT_W-1:0]     rsp_swap_in_slot
);

   lrups_cmd_type  cmd;
   lrups_stat_type stat;

   // sequence the scans: frames, then swap slots on a miss, then commit
   lrups_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   // hold the frame table, swap area, config and the result registers
   lrups_datapath #(
      .AGE_BITS (AGE_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_page           (req_page),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_valid          (rsp_valid),
      .rsp_hit            (rsp_hit),
      .rsp_frame          (rsp_frame),
      .rsp_evicted_valid  (rsp_evicted_valid),
      .rsp_evicted_page   (rsp_evicted_page),
      .rsp_swap_out_valid (rsp_swap_out_valid),
      .rsp_swap_out_slot  (rsp_swap_out_slot),
      .rsp_swap_in_valid  (rsp_swap_in_valid),
      .rsp_swap_in_slot   (rsp_swap_in_slot)
   );

endmodule

// ===== verif/swap_outcome_checker.sv =====
module swap_outcome_checker import lrups_pkg::*; #(
   parameter int AGE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [PAGE_W-1:0]     req_page,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_hit,
   input  logic [FRAME_W-1:0]    rsp_frame,
   input  logic                  rsp_evicted_valid,
   input  logic [PAGE_W-1:0]     rsp_evicted_page,
   input  logic                  rsp_swap_out_valid,
   input  logic [SLOT_W-1:0]     rsp_swap_out_slot,
   input  logic                  rsp_swap_in_valid,
   input  logic [SLOT_W-1:0]     rsp_swap_in_slot,
   output int                    errors,
   output int                    outstanding
);

   typedef struct packed {
      logic               hit;
      logic [FRAME_W-1:0] frame;
      logic               evicted_valid;
      logic [PAGE_W-1:0]  evicted_page;
      logic               swap_out_valid;
      logic [SLOT_W-1:0]  swap_out_slot;
      logic               swap_in_valid;
      logic [SLOT_W-1:0]  swap_in_slot;
   } outcome_type;

   // Mirror of the frame table and the swap area
   logic [PAGE_W-1:0]   held_page  [MAX_FRAMES];
   logic                held_valid [MAX_FRAMES];
   logic [AGE_BITS-1:0] held_age   [MAX_FRAMES];
   logic [PAGE_W-1:0]   slot_page  [MAX_PAGES];
   logic                slot_used  [MAX_PAGES];
   logic [NF_W-1:0]     frames_reg;
   logic [NS_W-1:0]     slots_reg;

   outcome_type pending_outcomes [$];
   int          refs_seen;

   task automatic note_mismatch(input string what, input logic [7:0] got_v,
                                input logic [7:0] want_v);
      if (errors < 40)
         $display("[%0t] reference %0d: %s is %0h, expected %0h",
                  $time, refs_seen, what, got_v, want_v);
      errors++;
   endtask

   // Age the searched frames by one, pinning at the counter ceiling
   function automatic void age_frames(input int count);
      int i;
      for (i = 0; i < count; i++)
         if (held_valid[i] && held_age[i] != '1)
            held_age[i] = held_age[i] + AGE_BITS'(1);
   endfunction

   function automatic outcome_type resolve_reference(input logic [PAGE_W-1:0] pg);
      outcome_type         o;
      int                  nf, ns, i, victim;
      bit                  found, have;
      logic [AGE_BITS-1:0] oldest;
      o = '0;
      if (frames_reg == 0) nf = 1;
      else if (frames_reg > MAX_FRAMES) nf = MAX_FRAMES;
      else nf = int'(frames_reg);
      if (slots_reg == 0) ns = 1;
      else if (slots_reg > MAX_PAGES) ns = MAX_PAGES;
      else ns = int'(slots_reg);

      found = 1'b0;
      victim = 0;
      for (i = 0; i < nf; i++) begin
         if (held_valid[i] && held_page[i] == pg) begin
            found = 1'b1;
            victim = i;
            break;
         end
      end
      if (found) begin
         age_frames(nf);
         held_age[victim] = '0;
         o.hit = 1'b1;
         o.frame = FRAME_W'(victim);
         return o;
      end

      // first empty frame, else the oldest one with the lowest index on ties
      have = 1'b0;
      oldest = '0;
      for (i = 0; i < nf; i++) begin
         if (!held_valid[i]) begin
            victim = i;
            break;
         end
         if (!have || held_age[i] > oldest) begin
            have = 1'b1;
            oldest = held_age[i];
            victim = i;
         end
      end

      if (held_valid[victim]) begin
         o.evicted_valid = 1'b1;
         o.evicted_page = held_page[victim];
         for (i = 0; i < ns; i++) begin
            if (!slot_used[i]) begin
               slot_used[i] = 1'b1;
               slot_page[i] = held_page[victim];
               o.swap_out_valid = 1'b1;
               o.swap_out_slot = SLOT_W'(i);
               break;
            end
         end
      end

      for (i = 0; i < ns; i++) begin
         if (slot_used[i] && slot_page[i] == pg) begin
            slot_used[i] = 1'b0;
            o.swap_in_valid = 1'b1;
            o.swap_in_slot = SLOT_W'(i);
            break;
         end
      end

      age_frames(nf);
      held_page[victim] = pg;
      held_valid[victim] = 1'b1;
      held_age[victim] = '0;
      o.frame = FRAME_W'(victim);
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type got, want;
      if (reset) begin
         held_valid = '{default: 1'b0};
         held_age = '{default: '0};
         slot_used = '{default: 1'b0};
         frames_reg = FRAMES_IN_USE_RESET;
         slots_reg = VIRTUAL_PAGES_RESET;
         pending_outcomes.delete();
         errors = 0;
         outstanding <= 0;
      end else begin
         // compare first: the next item may be taken on the strobe edge
         if (rsp_valid) begin
            got = {rsp_hit, rsp_frame, rsp_evicted_valid, rsp_evicted_page,
                   rsp_swap_out_valid, rsp_swap_out_slot, rsp_swap_in_valid,
                   rsp_swap_in_slot};
            if (pending_outcomes.size() == 0) begin
               note_mismatch("unrequested result, frame", got.frame, '0);
            end else begin
               want = pending_outcomes.pop_front();
               if (got.hit !== want.hit)
                  note_mismatch("hit", got.hit, want.hit);
               if (got.frame !== want.frame)
                  note_mismatch("frame", got.frame, want.frame);
               if (got.evicted_valid !== want.evicted_valid)
                  note_mismatch("evicted_valid", got.evicted_valid, want.evicted_valid);
               if (got.evicted_page !== want.evicted_page)
                  note_mismatch("evicted_page", got.evicted_page, want.evicted_page);
               if (got.swap_out_valid !== want.swap_out_valid)
                  note_mismatch("swap_out_valid", got.swap_out_valid, want.swap_out_valid);
               if (got.swap_out_slot !== want.swap_out_slot)
                  note_mismatch("swap_out_slot", got.swap_out_slot, want.swap_out_slot);
               if (got.swap_in_valid !== want.swap_in_valid)
                  note_mismatch("swap_in_valid", got.swap_in_valid, want.swap_in_valid);
               if (got.swap_in_slot !== want.swap_in_slot)
                  note_mismatch("swap_in_slot", got.swap_in_slot, want.swap_in_slot);
            end
            refs_seen++;
         end
         // an item taken on a register write edge still sees the old value
         if (start && !busy)
            pending_outcomes.push_back(resolve_reference(req_page));
         if (csr_write) begin
            case (csr_index)
               CSR_FRAMES_IN_USE: frames_reg = csr_data[NF_W-1:0];
               CSR_VIRTUAL_PAGES: slots_reg = csr_data[NS_W-1:0];
               default: ;
            endcase
         end
         outstanding <= pending_outcomes.size();
      end
   end

endmodule

// ===== verif/testbench.sv =====
module testbench;
   import lrups_pkg::*;

   localparam int AGE_BITS = 16;
   // Run limit, well above the slowest correct run.
   localparam int CYCLE_LIMIT = 3_000_000;
   // Settle at the end for longer than the longest miss takes.
   localparam int SETTLE_CYCLES = 100;
   // Hits on one frame while two others keep aging
   localparam int REPEAT_HITS = 20;
   // Register indexes the block does not decode
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [PAGE_W-1:0]     req_page = '0;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic                  rsp_valid;
   logic                  rsp_hit;
   logic [FRAME_W-1:0]    rsp_frame;
   logic                  rsp_evicted_valid;
   logic [PAGE_W-1:0]     rsp_evicted_page;
   logic                  rsp_swap_out_valid;
   logic [SLOT_W-1:0]     rsp_swap_out_slot;
   logic                  rsp_swap_in_valid;
   logic [SLOT_W-1:0]     rsp_swap_in_slot;
   int                    errors;
   int                    outstanding;
   int                    cycles;

   lru_page_replacement_swap_unit #(.AGE_BITS(AGE_BITS)) dut (.*);

   // Watches both channels and the register port, predicts every result and
   // counts mismatches; this module only makes stimulus and calls the verdict.
   swap_outcome_checker #(.AGE_BITS(AGE_BITS)) outcome_check (.*);

   always #6 clock = ~clock;

   // Hard stop in case the block hangs
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("lru_page_replacement_swap_unit: mismatch");
         $finish;
      end
   end

   // Drop start and hold until every predicted result has come back.
   // outstanding is registered in the checker, so let it update before the first look.
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Write both registers while the block is idle, then poke an index the
   // block does not decode with random data; it must change nothing.
   task automatic set_registers(input logic [CSR_DATA_W-1:0] frames_val,
                                input logic [CSR_DATA_W-1:0] pages_val);
      wait_drained();
      csr_write <= 1'b1;
      csr_index <= CSR_FRAMES_IN_USE;
      csr_data <= frames_val;
      @(posedge clock);
      csr_index <= CSR_VIRTUAL_PAGES;
      csr_data <= pages_val;
      @(posedge clock);
      csr_index <= $urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI;
      csr_data <= CSR_DATA_W'($urandom_range(0, 127));
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Hand one page reference to the block and return on the edge that takes it.
   // Start stays high between back-to-back items; it only drops for a gap.
   task automatic send_page(input logic [PAGE_W-1:0] pg, input bit may_idle);
      int gap;
      if (may_idle && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         // half the gaps start once the block has gone idle, the rest while
         // it is still scanning, so pauses land on every stage of its work
         if ($urandom_range(0, 1)) begin
            @(posedge clock);
            while (busy) @(posedge clock);
         end
         gap = $urandom_range(1, 10);
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_page <= pg;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Random references drawn mostly from a small working set that wanders,
   // so hits, evictions, swap-outs and swap-ins all happen; one in eight is
   // a page from anywhere. With gaps on, now and then drain the block completely.
   task automatic run_phase(input int ws, input int count, input bit may_idle);
      int                n;
      logic [PAGE_W-1:0] base;
      logic [PAGE_W-1:0] pg;
      base = PAGE_W'($urandom_range(0, 63));
      for (n = 0; n < count; n++) begin
         if ($urandom_range(0, 39) == 0)
            base = PAGE_W'($urandom_range(0, 63));
         if ($urandom_range(0, 7) == 0)
            pg = PAGE_W'($urandom_range(0, 63));
         else
            pg = base + PAGE_W'($urandom_range(0, ws - 1));
         send_page(pg, may_idle);
         if (may_idle && $urandom_range(0, 59) == 0)
            wait_drained();
      end
   endtask

   initial begin
      int k;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset configuration: two misses into empty frames at the page
      // extremes, then a hit.
      send_page(6'd0, 1'b1);
      send_page(6'd63, 1'b1);
      send_page(6'd0, 1'b1);

      // Two frames, two swap slots: evict into swap until it is full, drop
      // evicted pages, then pull pages back out of swap and hit again.
      set_registers(7'd2, 7'd2);
      send_page(6'd21, 1'b1);
      send_page(6'd42, 1'b1);
      send_page(6'd5, 1'b1);
      send_page(6'd63, 1'b1);
      send_page(6'd0, 1'b1);
      send_page(6'd0, 1'b1);

      // Shrink to one frame so the page already sitting in frame 1 is loaded
      // again into frame 0, then widen: the lower copy must be the one hit.
      set_registers(7'd1, 7'd2);
      send_page(6'd0, 1'b1);
      set_registers(7'd2, 7'd2);
      send_page(6'd0, 1'b1);
      send_page(6'd63, 1'b1);

      // Three frames: load three pages, then hit one of them back to back so
      // the other two keep aging. The next miss must take the oldest frame.
      set_registers(7'd3, 7'd4);
      send_page(6'd10, 1'b1);
      send_page(6'd11, 1'b1);
      send_page(6'd12, 1'b1);
      for (k = 0; k < REPEAT_HITS; k++)
         send_page(6'd12, 1'b0);
      send_page(6'd13, 1'b1);
      send_page(6'd11, 1'b1);

      // Random phases across settings, extremes included; out-of-range and
      // zero register values must clamp, upper data bits must be ignored.
      set_registers(7'd16, 7'd64);
      run_phase(20, 150, 1'b1);
      set_registers(7'd1, 7'd1);
      run_phase(3, 100, 1'b1);
      set_registers(7'd16, 7'd1);
      run_phase(24, 120, 1'b1);
      set_registers(7'd4, 7'd8);
      run_phase(7, 150, 1'b1);
      set_registers(7'd0, 7'd127);
      run_phase(4, 100, 1'b1);
      set_registers(7'd31, 7'd0);
      run_phase(24, 100, 1'b1);
      set_registers(7'h62, 7'd5);
      run_phase(5, 150, 1'b1);
      set_registers(7'd8, 7'd100);
      run_phase(12, 150, 1'b1);
      // last stretch back to back, no gaps
      set_registers(7'd16, 7'd64);
      run_phase(20, 200, 1'b0);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0 && outstanding == 0)
         $display("lru_page_replacement_swap_unit: match");
      else
         $display("lru_page_replacement_swap_unit: mismatch");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/lrups_pkg.sv
sv/lrups_ctrl.sv
sv/lrups_datapath.sv
sv/lru_page_replacement_swap_unit.sv
verif/swap_outcome_checker.sv
verif/testbench.sv
